/* hw/rtl/bb_pkg.sv */
package bb_pkg;

  localparam int COORD_W = 14;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W = 24;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIVS,
    ST_DIVW,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic start;
  } lane_ctrl_t;

endpackage

/* hw/rtl/bb_ram.sv */
module bb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 18432
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bb_lane.sv */
module bb_lane #(
  parameter int SUM_W = 17,
  parameter int CNT_W = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bb_pkg::lane_ctrl_t   ctrl,
  input  logic [7:0]           sample,
  input  logic [CNT_W-1:0]     count,
  output logic [7:0]           mean,
  output logic                 done
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, dvd[SUM_W-1]};
  assign fits  = trial >= {1'b0, count};
  assign mean  = dvd[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (ctrl.clr) begin
      busy <= 1'b0;
      done <= 1'b0;
      dvd  <= '0;
    end else if (ctrl.add) begin
      dvd <= dvd + SUM_W'(sample);
    end else if (ctrl.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      rem   <= '0;
      steps <= STEP_W'(SUM_W);
    end else if (busy) begin
      rem   <= fits ? CNT_W'(trial - {1'b0, count}) : trial[CNT_W-1:0];
      dvd   <= {dvd[SUM_W-2:0], fits};
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/bb_merge.sv */
module bb_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic        last,
  output logic        free,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {7'd0, 1'b0, red, green, blue};
      m_axis_tlast <= last;
    end
  end

endmodule

/* hw/rtl/box_blur_filter.sv */
// channel  dir  beat contents
// s_axis   in   tdata: blue, green, red; tuser: action (1 = store as zero)
// m_axis   out  tdata: blue, green, red, alpha; tlast: frame_last
// wr       in   wr_index selects radius, frame_width, frame_height
// While the window is still filling, an item is only stored; otherwise it
// also costs one line-store read per window pixel, then a bit-serial divide
// in each channel lane, and no new item is taken until the result is loaded.
// Reset and any register write restart the frame; the store is not cleared.
// A waiting result holds m_axis while the next item is taken in.
module box_blur_filter #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue, green, red
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // blue, green, red, alpha
  output logic        m_axis_tlast,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [12:0] wr_data
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int SRW = $clog2(STORE_ROWS);
  localparam int WIN = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_W = $clog2(WIN * 255 + 1);
  localparam int CNT_W = $clog2(WIN + 1);
  localparam int PW = $clog2(MAX_WIDTH * bb_pkg::MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH +
                             MAX_RADIUS);
  localparam int CW = bb_pkg::COORD_W;

  logic [3:0]  radius;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic        settle;

  logic [CW-1:0] r_eff, w_eff, h_eff;
  logic [PW-1:0] n_reg, d_reg;

  bb_pkg::state_t st, st_next;

  logic [PW-1:0]  in_pos, out_pos;
  logic [CW-1:0]  in_x, out_x, out_y;
  logic [SRW-1:0] in_srow, out_srow;

  logic [CW-1:0]  xlo, xhi, cx, rows_left;
  logic [SRW-1:0] sr;
  logic           rd_vld;
  logic [CNT_W-1:0] win_cnt;

  logic [CW-1:0]  ylo, yhi, k;
  logic [SRW-1:0] sr0;

  logic           accept, wr_any, pix_we, last_out, load, free;
  logic [23:0]    rd_data;
  logic [AW-1:0]  waddr, raddr;
  logic [2:0][7:0] means;
  logic [2:0]     ldone;
  bb_pkg::lane_ctrl_t lctrl;

  assign r_eff = (radius > MAX_RADIUS) ? CW'(MAX_RADIUS) : CW'(radius);
  assign w_eff = (frame_width == 11'd0) ? CW'(1) :
                 (frame_width > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(frame_width);
  assign h_eff = (frame_height == 13'd0) ? CW'(1) :
                 (frame_height > bb_pkg::MAX_HEIGHT) ? CW'(bb_pkg::MAX_HEIGHT) :
                 CW'(frame_height);

  assign wr_any = wr_en && (wr_index != bb_pkg::REG_NONE);
  assign s_axis_tready = (st == bb_pkg::ST_IDLE) && !settle;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pix_we = accept && (in_pos < n_reg);
  assign last_out = (PW'(out_pos) + PW'(1)) >= n_reg;

  assign waddr = AW'(in_srow) * AW'(MAX_WIDTH) + AW'(in_x);
  assign raddr = AW'(sr) * AW'(MAX_WIDTH) + AW'(cx);

  assign ylo = (out_y >= r_eff) ? out_y - r_eff : '0;
  assign yhi = (out_y + r_eff >= h_eff) ? h_eff - 1'b1 : out_y + r_eff;
  assign k   = out_y - ylo;
  assign sr0 = (CW'(out_srow) >= k) ? SRW'(CW'(out_srow) - k) :
               SRW'(CW'(out_srow) + CW'(STORE_ROWS) - k);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 4'd1;
      frame_width  <= 11'd640;
      frame_height <= 13'd480;
      settle       <= 1'b1;
    end else begin
      settle <= wr_any;
      if (wr_en) begin
        case (wr_index)
          bb_pkg::REG_RADIUS: radius       <= wr_data[3:0];
          bb_pkg::REG_WIDTH:  frame_width  <= wr_data[10:0];
          bb_pkg::REG_HEIGHT: frame_height <= wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_reg <= PW'(w_eff) * PW'(h_eff);
    d_reg <= PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= bb_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    lctrl   = '0;
    load    = 1'b0;
    case (st)
      bb_pkg::ST_IDLE: begin
        if (accept && in_pos >= d_reg) st_next = bb_pkg::ST_SETUP;
      end
      bb_pkg::ST_SETUP: begin
        lctrl.clr = 1'b1;
        st_next   = bb_pkg::ST_SWEEP;
      end
      bb_pkg::ST_SWEEP: begin
        lctrl.add = rd_vld;
        if (cx == xhi && rows_left == '0) st_next = bb_pkg::ST_DRAIN;
      end
      bb_pkg::ST_DRAIN: begin
        lctrl.add = rd_vld;
        st_next   = bb_pkg::ST_DIVS;
      end
      bb_pkg::ST_DIVS: begin
        lctrl.start = 1'b1;
        st_next     = bb_pkg::ST_DIVW;
      end
      bb_pkg::ST_DIVW: begin
        if (ldone[0]) st_next = bb_pkg::ST_EMIT;
      end
      bb_pkg::ST_EMIT: begin
        if (free) begin
          load    = 1'b1;
          st_next = bb_pkg::ST_IDLE;
        end
      end
      default: st_next = bb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_vld <= (st == bb_pkg::ST_SWEEP);
    case (st)
      bb_pkg::ST_SETUP: begin
        xlo       <= (out_x >= r_eff) ? out_x - r_eff : '0;
        xhi       <= (out_x + r_eff >= w_eff) ? w_eff - 1'b1 : out_x + r_eff;
        cx        <= (out_x >= r_eff) ? out_x - r_eff : '0;
        rows_left <= yhi - ylo;
        sr        <= sr0;
        win_cnt   <= '0;
      end
      bb_pkg::ST_SWEEP: begin
        if (rd_vld) win_cnt <= win_cnt + 1'b1;
        if (cx == xhi) begin
          cx        <= xlo;
          rows_left <= rows_left - 1'b1;
          sr        <= (sr == SRW'(STORE_ROWS - 1)) ? '0 : sr + 1'b1;
        end else begin
          cx <= cx + 1'b1;
        end
      end
      bb_pkg::ST_DRAIN: begin
        if (rd_vld) win_cnt <= win_cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || wr_any || (load && last_out)) begin
      in_pos   <= '0;
      in_x     <= '0;
      in_srow  <= '0;
      out_pos  <= '0;
      out_x    <= '0;
      out_y    <= '0;
      out_srow <= '0;
    end else begin
      if (accept) begin
        in_pos <= in_pos + 1'b1;
        if (in_x + 1'b1 >= w_eff) begin
          in_x    <= '0;
          in_srow <= (in_srow == SRW'(STORE_ROWS - 1)) ? '0 : in_srow + 1'b1;
        end else begin
          in_x <= in_x + 1'b1;
        end
      end
      if (load) begin
        out_pos <= out_pos + 1'b1;
        if (out_x + 1'b1 >= w_eff) begin
          out_x    <= '0;
          out_y    <= out_y + 1'b1;
          out_srow <= (out_srow == SRW'(STORE_ROWS - 1)) ? '0 : out_srow + 1'b1;
        end else begin
          out_x <= out_x + 1'b1;
        end
      end
    end
  end

  bb_ram #(.WIDTH(bb_pkg::PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (pix_we),
    .waddr (waddr),
    .wdata (s_axis_tuser[0] ? 24'd0 : s_axis_tdata),
    .re    (st == bb_pkg::ST_SWEEP),
    .raddr (raddr),
    .rdata (rd_data)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    bb_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lctrl),
      .sample (rd_data[8*i +: 8]),
      .count  (win_cnt),
      .mean   (means[i]),
      .done   (ldone[i])
    );
  end

  bb_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .blue          (means[0]),
    .green         (means[1]),
    .red           (means[2]),
    .last          (last_out),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (st == bb_pkg::ST_IDLE) && !settle)
    else $error("beat taken while busy");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (st == bb_pkg::ST_DIVS) |-> (win_cnt != '0))
    else $error("empty window at divide");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (ldone[0] == ldone[1]) && (ldone[1] == ldone[2]))
    else $error("lanes out of step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result overwritten");
`endif

endmodule

/* dv/tb_box_blur_filter.sv */
module tb_box_blur_filter;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 600;
  localparam int ITEM_TARGET = 1600;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       alpha;
    logic       last;
  } pixel_result_t;

  typedef enum logic { ROW_PIX, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bb_pkg::reg_index_t idx;
    int                 val;
    logic               act;
    logic [23:0]        pix;
    logic               typed;
    pixel_result_t      res;
  } blur_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // blue, green, red
  logic [0:0]  s_axis_tuser = '0;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // blue, green, red, alpha
  logic        m_axis_tlast;
  logic        wr_en = 1'b0;
  bb_pkg::reg_index_t wr_index = bb_pkg::REG_RADIUS;
  logic [12:0] wr_data = '0;

  box_blur_filter u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // blur state mirror
  int unsigned   radius_reg = 1;
  int unsigned   width_reg = 640;
  int unsigned   height_reg = 480;
  int unsigned   in_pos = 0;
  int unsigned   out_pos = 0;
  logic [23:0]   frame_pix [int];
  pixel_result_t blur_q [$];

  int  errors = 0;
  int  items_sent = 0;
  bit  calm = 0;
  int  hold_cycles = 0;
  int  stall_left = 0;

  blur_row_t rows [21] = '{
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'h030201, 1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b1, 24'hFFFFFF, 1'b0, '0},
    '{ROW_REG, bb_pkg::REG_NONE,   5,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_REG, bb_pkg::REG_RADIUS, 0,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_REG, bb_pkg::REG_WIDTH,  2,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_REG, bb_pkg::REG_HEIGHT, 2,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'h000000, 1'b1,
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'hFFFFFF, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b1, 24'hABCDEF, 1'b1,
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'h0FA55A, 1'b1,
      '{8'h5A, 8'hA5, 8'h0F, 1'b0, 1'b1}},
    '{ROW_REG, bb_pkg::REG_RADIUS, 1,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_REG, bb_pkg::REG_WIDTH,  1,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_REG, bb_pkg::REG_HEIGHT, 1,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'hFFFFFF, 1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'h070707, 1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b1, 24'h090909, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1}},
    '{ROW_REG, bb_pkg::REG_WIDTH,  3,  1'b0, 24'h0,      1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'h123456, 1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'h654321, 1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b0, 24'hFF00FF, 1'b0, '0},
    '{ROW_PIX, bb_pkg::REG_NONE,   0,  1'b1, 24'h00FF00, 1'b0, '0}
  };

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic blur_predict(input logic act, input logic [23:0] d,
                              output bit has, output pixel_result_t e);
    int r, w, h, n, dl, p, j, y0, x0, yy, xx, bs, gs, rs, cnt;
    logic [23:0] v;
    r  = radius_reg > 8 ? 8 : radius_reg;
    w  = width_reg == 0 ? 1 : (width_reg > 1024 ? 1024 : width_reg);
    h  = height_reg == 0 ? 1 : (height_reg > 4096 ? 4096 : height_reg);
    n  = w * h;
    dl = r * w + r;
    p  = in_pos;
    has = 0;
    e = '0;
    if (p < n) frame_pix[p] = act ? 24'h0 : d;
    if (p < dl) begin
      in_pos = p + 1;
      return;
    end
    j = out_pos;
    y0 = j / w;
    x0 = j % w;
    bs = 0; gs = 0; rs = 0; cnt = 0;
    for (yy = y0 - r; yy <= y0 + r; yy++) begin
      if (yy < 0 || yy >= h) continue;
      for (xx = x0 - r; xx <= x0 + r; xx++) begin
        if (xx < 0 || xx >= w) continue;
        v = frame_pix[yy * w + xx];
        bs += v[7:0];
        gs += v[15:8];
        rs += v[23:16];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    has = 1;
    e.blue  = 8'(bs / cnt);
    e.green = 8'(gs / cnt);
    e.red   = 8'(rs / cnt);
    e.alpha = 1'b0;
    e.last  = (j + 1 >= n);
    if (j + 1 >= n) begin
      in_pos = 0;
      out_pos = 0;
      frame_pix.delete();
    end else begin
      in_pos = p + 1;
      out_pos = j + 1;
    end
  endtask

  task automatic drive_pixel(input logic act, input logic [23:0] d,
                             input logic typed, input pixel_result_t tres);
    bit has;
    pixel_result_t e;
    int gap;
    blur_predict(act, d, has, e);
    if (has) blur_q.push_back(typed ? tres : e);
    gap = idle_draw();
    @(negedge clk);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_reg(input bb_pkg::reg_index_t idx, input int val);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (blur_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= 13'(val);
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      bb_pkg::REG_RADIUS: radius_reg = val & 'hF;
      bb_pkg::REG_WIDTH:  width_reg = val & 'h7FF;
      bb_pkg::REG_HEIGHT: height_reg = val & 'h1FFF;
      default: return;
    endcase
    in_pos = 0;
    out_pos = 0;
    frame_pix.delete();
  endtask

  task automatic run_frame(input int r, input int w, input int h, input int cap);
    int re, we, he, total;
    logic act;
    write_reg(bb_pkg::REG_RADIUS, r);
    write_reg(bb_pkg::REG_WIDTH, w);
    write_reg(bb_pkg::REG_HEIGHT, h);
    re = r > 8 ? 8 : r;
    we = w == 0 ? 1 : (w > 1024 ? 1024 : w);
    he = h == 0 ? 1 : (h > 4096 ? 4096 : h);
    total = we * he + re * we + re;
    if (cap > 0 && cap < total) total = cap;
    for (int k = 0; k < total; k++) begin
      act = (k < we * he) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
      drive_pixel(act, 24'($urandom), 1'b0, '0);
    end
  endtask

  task automatic report(input string what, input pixel_result_t e, input pixel_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected b%02h g%02h r%02h a%0d l%0d got b%02h g%02h r%02h a%0d l%0d",
               $realtime, what, e.blue, e.green, e.red, e.alpha, e.last,
               got.blue, got.green, got.red, got.alpha, got.last);
  endtask

  always @(posedge clk) begin
    pixel_result_t got, e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.blue  = m_axis_tdata[7:0];
      got.green = m_axis_tdata[15:8];
      got.red   = m_axis_tdata[23:16];
      got.alpha = m_axis_tdata[24];
      got.last  = m_axis_tlast;
      if (blur_q.size() == 0) begin
        report("unexpected beat", '0, got);
      end else begin
        e = blur_q.pop_front();
        if (got !== e) report("beat mismatch", e, got);
      end
      stall_left = idle_draw();
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int loop_no;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) write_reg(rows[i].idx, rows[i].val);
      else drive_pixel(rows[i].act, rows[i].pix, rows[i].typed, rows[i].res);
    end

    // clamped and extreme settings, partly as cut-off frames
    run_frame(0, 2047, 8191, 150);
    run_frame(15, 3, 2, 0);
    run_frame(1, 0, 0, 0);
    run_frame(8, 17, 17, 0);
    run_frame(1, 1024, 3, 400);
    run_frame(0, 1, 4096, 100);
    run_frame(2, 5, 7, 0);

    loop_no = 0;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if (loop_no == 0) begin
        write_reg(bb_pkg::REG_RADIUS, 2);
        write_reg(bb_pkg::REG_WIDTH, 6);
        write_reg(bb_pkg::REG_HEIGHT, 5);
        for (int k = 0; k < 30; k++) drive_pixel(1'b0, 24'($urandom), 1'b0, '0);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (blur_q.size() == 0);
        for (int k = 0; k < 15; k++)
          drive_pixel(1'($urandom_range(0, 1)), 24'($urandom), 1'b0, '0);
        write_reg(bb_pkg::REG_RADIUS, 1);
        write_reg(bb_pkg::REG_WIDTH, 8);
        write_reg(bb_pkg::REG_HEIGHT, 6);
        hold_cycles = 3000;
        for (int k = 0; k < 57; k++) drive_pixel(1'b0, 24'($urandom), 1'b0, '0);
      end
      if ($urandom_range(0, 7) == 0)
        run_frame($urandom_range(0, 15), $urandom_range(1, 40), $urandom_range(1, 6), 0);
      else
        run_frame($urandom_range(0, 4), $urandom_range(1, 16), $urandom_range(1, 12), 0);
      loop_no++;
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (blur_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && blur_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
